[src/tcf_pkg.sv]
// Shared types, widths and constants for the tilt complementary filter.
// Holds the sequencer state type and the CORDIC arctangent table in degrees.
// No dependencies.
package tcf_pkg;

   localparam int FRAC_BITS    = 16;
   localparam int CORDIC_STEPS = 16;
   localparam int TABLE_FRAC   = 24;
   localparam int TABLE_LEN    = 24;

   localparam int ACCEL_W = 16;
   localparam int RATE_W  = 28;
   localparam int ANGLE_W = 25;
   localparam int ALPHA_W = 17;
   localparam int SR_W    = 13;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 17;

   localparam int SUM_W   = RATE_W + 1;
   localparam int REM_W   = SR_W + 1;
   localparam int XY_W    = 36;
   localparam int Z_W     = 35;
   localparam int ROUND_SH = TABLE_FRAC - FRAC_BITS;
   localparam int ACC_W   = Z_W - ROUND_SH;
   localparam int ALPHA_FRAC = 16;
   localparam int PROD_W  = ALPHA_W + 1 + SUM_W;
   localparam int MAC_W   = PROD_W + 1;
   localparam int NV_W    = MAC_W - ALPHA_FRAC;
   localparam int CNT_W   = $clog2(RATE_W);

   localparam logic [CSR_IDX_W-1:0] CSR_BLEND_ALPHA   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_RATE   = 2'd1;

   localparam logic [ALPHA_W-1:0] ALPHA_ONE   = ALPHA_W'(65536);
   localparam logic [ALPHA_W-1:0] ALPHA_RESET = ALPHA_W'(64225);
   localparam logic [SR_W-1:0]    SR_RESET    = SR_W'(104);

   localparam logic signed [Z_W-1:0]  Z_HALF_TURN = Z_W'(180 * (64'sd1 <<< TABLE_FRAC));
   localparam logic signed [Z_W-1:0]  Z_ROUND     = Z_W'(64'sd1 <<< (ROUND_SH - 1));
   localparam logic signed [MAC_W-1:0] MAC_ROUND  = MAC_W'(64'sd1 <<< (ALPHA_FRAC - 1));
   localparam logic signed [NV_W-1:0] ANGLE_LIM   = NV_W'(180 * (64'sd1 <<< FRAC_BITS));
   localparam logic signed [NV_W-1:0] ANGLE_TURN  = NV_W'(360 * (64'sd1 <<< FRAC_BITS));

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_ROTATE,
      ST_MUL_GYRO,
      ST_MUL_ACCEL,
      ST_WRAP,
      ST_DONE
   } state_type;

   function automatic logic [Z_W-1:0] atan_deg_q24(input logic [CNT_W-1:0] idx);
      logic [Z_W-1:0] val;
      unique case (idx)
         5'd0:    val = Z_W'(754974720);
         5'd1:    val = Z_W'(445687602);
         5'd2:    val = Z_W'(235489088);
         5'd3:    val = Z_W'(119537938);
         5'd4:    val = Z_W'(60000934);
         5'd5:    val = Z_W'(30029717);
         5'd6:    val = Z_W'(15018523);
         5'd7:    val = Z_W'(7509720);
         5'd8:    val = Z_W'(3754917);
         5'd9:    val = Z_W'(1877466);
         5'd10:   val = Z_W'(938734);
         5'd11:   val = Z_W'(469367);
         5'd12:   val = Z_W'(234684);
         5'd13:   val = Z_W'(117342);
         5'd14:   val = Z_W'(58671);
         5'd15:   val = Z_W'(29335);
         5'd16:   val = Z_W'(14668);
         5'd17:   val = Z_W'(7334);
         5'd18:   val = Z_W'(3667);
         5'd19:   val = Z_W'(1833);
         5'd20:   val = Z_W'(917);
         5'd21:   val = Z_W'(458);
         5'd22:   val = Z_W'(229);
         5'd23:   val = Z_W'(115);
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

[src/tilt_complementary_filter.sv]
// Sequence: bit-serial divide, CORDIC_STEPS rotate steps, gyro multiply, accel multiply,
// wrap until in range, then done, from an accepted request beat to a valid response beat.
// Beats are taken only in idle, after the last is done, as set by the bit-serial divider
// and single shared CORDIC add/shift stage. The response register frees the request side.
// Reset (synchronous): angle clears to zero, alpha to 64225, sample rate to 104 Hz.
// Depends on tcf_pkg.
module tilt_complementary_filter
   import tcf_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [ACCEL_W-1:0]    req_accel_x,
   input  logic signed [ACCEL_W-1:0]    req_accel_y,
   input  logic signed [RATE_W-1:0]     req_gyro_rate_z,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [ANGLE_W-1:0]    rsp_tilt_angle,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [CSR_IDX_W-1:0]         csr_index,
   input  logic [CSR_DATA_W-1:0]        csr_data
);

   state_type state_ff, state_in;

   logic [ALPHA_W-1:0]        alpha_ff;
   logic [SR_W-1:0]           sr_ff;
   logic signed [ANGLE_W-1:0] angle_ff;
   logic                      rsp_valid_ff;
   logic signed [ANGLE_W-1:0] rsp_angle_ff;

   logic [CNT_W-1:0]          cnt_ff;
   logic [RATE_W-1:0]         dq_ff;
   logic [REM_W-1:0]          rem_ff;
   logic                      rate_neg_ff;
   logic signed [XY_W-1:0]    x_ff, y_ff;
   logic signed [Z_W-1:0]     z_ff;
   logic                      acc_zero_ff;
   logic signed [SUM_W-1:0]   sum_ff;
   logic signed [ACC_W-1:0]   acc_ff;
   logic signed [MAC_W-1:0]   mac_ff;
   logic signed [NV_W-1:0]    nv_ff;

   logic accept, rsp_free, div_last, rot_last, wrap_hi, wrap_lo;

   // control strobes
   logic ld_item, do_div, do_rot, do_mul_gyro, do_mul_accel, do_wrap, do_done;

   assign accept   = req_valid && req_ready;
   assign rsp_free = !rsp_valid_ff || rsp_ready;
   assign div_last = (cnt_ff == CNT_W'(RATE_W - 1));
   assign rot_last = (cnt_ff == CNT_W'(CORDIC_STEPS - 1));
   assign wrap_hi  = (nv_ff > ANGLE_LIM);
   assign wrap_lo  = (nv_ff < -ANGLE_LIM);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:      if (accept) state_in = ST_DIVIDE;
         ST_DIVIDE:    if (div_last) state_in = ST_ROTATE;
         ST_ROTATE:    if (rot_last) state_in = ST_MUL_GYRO;
         ST_MUL_GYRO:  state_in = ST_MUL_ACCEL;
         ST_MUL_ACCEL: state_in = ST_WRAP;
         ST_WRAP:      if (!wrap_hi && !wrap_lo) state_in = ST_DONE;
         ST_DONE:      if (rsp_free) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready    = (state_ff == ST_IDLE);
      ld_item      = accept;
      do_div       = (state_ff == ST_DIVIDE);
      do_rot       = (state_ff == ST_ROTATE);
      do_mul_gyro  = (state_ff == ST_MUL_GYRO);
      do_mul_accel = (state_ff == ST_MUL_ACCEL);
      do_wrap      = (state_ff == ST_WRAP);
      do_done      = (state_ff == ST_DONE) && rsp_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // configuration
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff <= ALPHA_RESET;
         sr_ff    <= SR_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_BLEND_ALPHA: alpha_ff <= csr_data[ALPHA_W-1:0];
            CSR_SAMPLE_RATE: sr_ff    <= csr_data[SR_W-1:0];
            default: ;
         endcase
      end
   end

   logic [ALPHA_W-1:0] alpha_eff;
   logic [SR_W-1:0]    sr_eff;

   assign alpha_eff = (alpha_ff > ALPHA_ONE) ? ALPHA_ONE : alpha_ff;
   assign sr_eff    = (sr_ff == '0) ? SR_W'(1) : sr_ff;

   // load of a new item
   logic signed [XY_W-1:0] ax_scaled, ay_scaled;
   logic [RATE_W-1:0]      rate_mag;

   assign ax_scaled = {{(XY_W-ACCEL_W-16){req_accel_x[ACCEL_W-1]}}, req_accel_x, 16'b0};
   assign ay_scaled = {{(XY_W-ACCEL_W-16){req_accel_y[ACCEL_W-1]}}, req_accel_y, 16'b0};
   assign rate_mag  = req_gyro_rate_z[RATE_W-1] ? RATE_W'(-req_gyro_rate_z)
                                                 : RATE_W'(req_gyro_rate_z);

   // restoring divide, one quotient bit per cycle
   logic [REM_W-1:0]        rem_shift, rem_diff;
   logic                    q_bit;
   logic signed [SUM_W-1:0] q_signed, sum_next;

   assign rem_shift = {rem_ff[REM_W-2:0], dq_ff[RATE_W-1]};
   assign rem_diff  = rem_shift - {1'b0, sr_eff};
   assign q_bit     = (rem_shift >= {1'b0, sr_eff});
   assign q_signed  = rate_neg_ff ? -$signed({1'b0, dq_ff}) : $signed({1'b0, dq_ff});
   assign sum_next  = {{(SUM_W-ANGLE_W){angle_ff[ANGLE_W-1]}}, angle_ff} + q_signed;

   // shared CORDIC stage
   logic signed [XY_W-1:0] xs, ys;
   logic signed [Z_W-1:0]  atan_step, z_rounded;

   assign xs        = x_ff >>> cnt_ff;
   assign ys        = y_ff >>> cnt_ff;
   assign atan_step = $signed(atan_deg_q24(cnt_ff));
   assign z_rounded = (z_ff + Z_ROUND) >>> ROUND_SH;

   // shared multiplier: weight times operand
   logic [ALPHA_W-1:0]       mul_w;
   logic signed [SUM_W-1:0]  mul_b;
   logic signed [PROD_W-1:0] prod;
   logic signed [MAC_W-1:0]  prod_ext, mac_total;

   assign mul_w     = do_mul_gyro ? alpha_eff : ALPHA_W'(ALPHA_ONE - alpha_eff);
   assign mul_b     = do_mul_gyro ? sum_ff
                                  : {{(SUM_W-ACC_W){acc_ff[ACC_W-1]}}, acc_ff};
   assign prod      = $signed({1'b0, mul_w}) * mul_b;
   assign prod_ext  = {{(MAC_W-PROD_W){prod[PROD_W-1]}}, prod};
   assign mac_total = mac_ff + prod_ext;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (ld_item || (do_div && div_last) || do_rot && rot_last) begin
         cnt_ff <= '0;
      end else if (do_div || do_rot) begin
         cnt_ff <= cnt_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (ld_item) begin
         dq_ff       <= rate_mag;
         rem_ff      <= '0;
         rate_neg_ff <= req_gyro_rate_z[RATE_W-1];
         acc_zero_ff <= (req_accel_x == '0) && (req_accel_y == '0);
         if (req_accel_x[ACCEL_W-1]) begin
            x_ff <= -ax_scaled;
            y_ff <= -ay_scaled;
            z_ff <= req_accel_y[ACCEL_W-1] ? -Z_HALF_TURN : Z_HALF_TURN;
         end else begin
            x_ff <= ax_scaled;
            y_ff <= ay_scaled;
            z_ff <= '0;
         end
      end
      if (do_div) begin
         rem_ff <= q_bit ? rem_diff : rem_shift;
         dq_ff  <= {dq_ff[RATE_W-2:0], q_bit};
      end
      if (do_rot) begin
         if (cnt_ff == '0) begin
            sum_ff <= sum_next;
         end
         if (!y_ff[XY_W-1]) begin
            x_ff <= x_ff + ys;
            y_ff <= y_ff - xs;
            z_ff <= z_ff + atan_step;
         end else begin
            x_ff <= x_ff - ys;
            y_ff <= y_ff + xs;
            z_ff <= z_ff - atan_step;
         end
      end
      if (do_mul_gyro) begin
         acc_ff <= acc_zero_ff ? '0 : z_rounded[ACC_W-1:0];
         mac_ff <= MAC_ROUND + prod_ext;
      end
      if (do_mul_accel) begin
         nv_ff <= mac_total[MAC_W-1:ALPHA_FRAC];
      end
      if (do_wrap) begin
         if (wrap_hi) begin
            nv_ff <= nv_ff - ANGLE_TURN;
         end else if (wrap_lo) begin
            nv_ff <= nv_ff + ANGLE_TURN;
         end
      end
   end

   // stored angle and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         angle_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (do_done) begin
         angle_ff     <= nv_ff[ANGLE_W-1:0];
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (do_done) begin
         rsp_angle_ff <= nv_ff[ANGLE_W-1:0];
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_tilt_angle = rsp_angle_ff;

   a_angle_in_range: assert property (@(posedge clock) disable iff (reset)
      ($signed({{(NV_W-ANGLE_W){angle_ff[ANGLE_W-1]}}, angle_ff}) <= ANGLE_LIM) &&
      ($signed({{(NV_W-ANGLE_W){angle_ff[ANGLE_W-1]}}, angle_ff}) >= -ANGLE_LIM))
      else $error("stored angle outside half turn");

   a_done_loads_rsp: assert property (@(posedge clock) disable iff (reset)
      do_done |=> rsp_valid_ff && (rsp_angle_ff == angle_ff))
      else $error("response beat does not match stored angle");

   a_accept_starts_divide: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_DIVIDE) && (cnt_ff == '0))
      else $error("accepted beat did not start the divide");

   a_rotate_after_divide: assert property (@(posedge clock) disable iff (reset)
      (do_div && div_last) |=> (state_ff == ST_ROTATE) && (cnt_ff == '0))
      else $error("rotation did not follow the last quotient bit");

endmodule

[tb/tilt_complementary_filter_tb.sv]
// Self-checking testbench for tilt_complementary_filter: directed and random request beats,
// register sweeps, random idling on both channels and a long response stall.
// Depends on tcf_pkg and the tilt_complementary_filter RTL.
module tilt_complementary_filter_tb
   import tcf_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_B = 2'd3;
   localparam longint HALF_TURN_Q24 = 180 * (64'sd1 <<< TABLE_FRAC);
   localparam longint LIMIT_Q16     = 180 * (64'sd1 <<< FRAC_BITS);
   localparam longint TURN_Q16      = 360 * (64'sd1 <<< FRAC_BITS);
   localparam int SWEEP_ITEMS = 160;
   localparam int DRAIN_CYCLES = 64;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic signed [ACCEL_W-1:0]  req_accel_x = '0;
   logic signed [ACCEL_W-1:0]  req_accel_y = '0;
   logic signed [RATE_W-1:0]   req_gyro_rate_z = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic signed [ANGLE_W-1:0]  rsp_tilt_angle;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_IDX_W-1:0]       csr_index = '0;
   logic [CSR_DATA_W-1:0]      csr_data = '0;

   longint atan_q24 [TABLE_LEN] = '{
      754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
      15018523, 7509720, 3754917, 1877466, 938734, 469367,
      234684, 117342, 58671, 29335, 14668, 7334,
      3667, 1833, 917, 458, 229, 115
   };

   longint             angle_model = 0;
   logic [ALPHA_W-1:0] alpha_model = ALPHA_RESET;
   logic [SR_W-1:0]    rate_hz_model = SR_RESET;

   logic signed [ANGLE_W-1:0] tilt_expect_q [$];
   logic signed [ANGLE_W-1:0] want_angle;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int stall_request = 0;
   int stall_left = 0;
   int samples_sent = 0;
   int angles_checked = 0;
   int csr_writes = 0;
   int mismatch_count = 0;

   tilt_complementary_filter uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_accel_x     (req_accel_x),
      .req_accel_y     (req_accel_y),
      .req_gyro_rate_z (req_gyro_rate_z),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_tilt_angle  (rsp_tilt_angle),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   always #5 clock = ~clock;

   function automatic longint accel_angle_q16(input longint ay, input longint ax);
      longint x, y, z, xs, ys;
      if (ax == 0 && ay == 0) return 0;
      x = ax * 65536;
      y = ay * 65536;
      z = 0;
      if (x < 0) begin
         z = (y >= 0) ? HALF_TURN_Q24 : -HALF_TURN_Q24;
         x = -x;
         y = -y;
      end
      for (int i = 0; i < CORDIC_STEPS && i < TABLE_LEN; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y >= 0) begin
            x = x + ys;
            y = y - xs;
            z = z + atan_q24[i];
         end else begin
            x = x - ys;
            y = y + xs;
            z = z - atan_q24[i];
         end
      end
      return (z + (64'sd1 <<< (ROUND_SH - 1))) >>> ROUND_SH;
   endfunction

   function automatic logic signed [ANGLE_W-1:0] advance_tilt(input longint ax,
                                                              input longint ay,
                                                              input longint gz);
      longint alpha, hz, sum, acc, nv;
      alpha = (alpha_model > ALPHA_ONE) ? longint'(ALPHA_ONE) : longint'(alpha_model);
      hz = (rate_hz_model == 0) ? 64'sd1 : longint'(rate_hz_model);
      sum = angle_model + gz / hz;
      acc = accel_angle_q16(ay, ax);
      nv = (alpha * sum + (longint'(ALPHA_ONE) - alpha) * acc + 32768) >>> ALPHA_FRAC;
      while (nv > LIMIT_Q16) nv = nv - TURN_Q16;
      while (nv < -LIMIT_Q16) nv = nv + TURN_Q16;
      angle_model = nv;
      return ANGLE_W'(nv);
   endfunction

   task automatic report_mismatch(input string what);
      $display("mismatch %0d: %s", mismatch_count + 1, what);
      mismatch_count++;
   endtask

   task automatic send_sample(input logic signed [ACCEL_W-1:0] ax,
                              input logic signed [ACCEL_W-1:0] ay,
                              input logic signed [RATE_W-1:0]  gz);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_accel_x     <= ax;
      req_accel_y     <= ay;
      req_gyro_rate_z <= gz;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      tilt_expect_q.push_back(advance_tilt(longint'(ax), longint'(ay), longint'(gz)));
      samples_sent++;
   endtask

   task automatic send_random_sample();
      logic signed [ACCEL_W-1:0] ax, ay;
      logic signed [RATE_W-1:0]  gz;
      int pick;
      pick = $urandom_range(15);
      ax = ACCEL_W'($urandom);
      ay = ACCEL_W'($urandom);
      gz = RATE_W'(int'($urandom_range(65536000)) - 32768000);
      case (pick)
         0: begin
            ax = '0;
            ay = '0;
         end
         1: ax = '0;
         2: begin
            ay = '0;
            ax = {1'b1, ax[ACCEL_W-2:0]};
         end
         3, 4, 5: gz = RATE_W'($urandom);
         default: ;
      endcase
      send_sample(ax, ay, gz);
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (tilt_expect_q.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      wait_idle();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == CSR_BLEND_ALPHA) alpha_model = data[ALPHA_W-1:0];
      else if (idx == CSR_SAMPLE_RATE) rate_hz_model = data[SR_W-1:0];
      csr_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic choose_random_setting();
      logic [ALPHA_W-1:0] alpha;
      logic [SR_W-1:0]    hz;
      logic [3:0]         spare;
      case ($urandom_range(5))
         0: alpha = '0;
         1: alpha = ALPHA_ONE;
         2: alpha = ALPHA_W'($urandom_range(131071, 65537));
         3: alpha = ALPHA_W'($urandom_range(131071));
         default: alpha = ALPHA_W'($urandom_range(65535, 49152));
      endcase
      case ($urandom_range(6))
         0: hz = '0;
         1: hz = SR_W'(1);
         2: hz = SR_W'(6664);
         3: hz = '1;
         default: hz = SR_W'($urandom_range(6664, 1));
      endcase
      spare = 4'($urandom);
      write_csr(CSR_BLEND_ALPHA, alpha);
      write_csr(CSR_SAMPLE_RATE, {spare, hz});
   endtask

   task automatic test_reset_defaults();
      send_sample(16'sd16384, 16'sd0, '0);
      send_sample(16'sd0, 16'sd16384, RATE_W'(10 * 65536));
   endtask

   task automatic test_accel_quadrants();
      write_csr(CSR_BLEND_ALPHA, '0);
      send_sample(16'sd0, 16'sd0, '0);
      send_sample(16'sd32767, 16'sd0, '0);
      send_sample(-16'sd32768, 16'sd0, '0);
      send_sample(-16'sd32768, -16'sd1, '0);
      send_sample(-16'sd32768, 16'sd32767, '0);
      send_sample(16'sd0, 16'sd32767, '0);
      send_sample(16'sd0, -16'sd32768, '0);
      send_sample(16'sd32767, 16'sd32767, '0);
      send_sample(-16'sd32768, -16'sd32768, '0);
      send_sample(-16'sd1, 16'sd1, '0);
      send_sample(16'sd1, -16'sd32768, '0);
   endtask

   task automatic test_gyro_wrap();
      longint step;
      write_csr(CSR_BLEND_ALPHA, ALPHA_ONE);
      write_csr(CSR_SAMPLE_RATE, 17'd1);
      send_sample(16'sd100, 16'sd100, {1'b0, {(RATE_W-1){1'b1}}});
      send_sample(-16'sd100, 16'sd5, {1'b1, {(RATE_W-1){1'b0}}});
      step = LIMIT_Q16 - angle_model;
      send_sample(16'sd7, -16'sd3, RATE_W'(step));
      send_sample(16'sd7, -16'sd3, '0);
      send_sample(16'sd7, -16'sd3, RATE_W'(1));
      step = -LIMIT_Q16 - angle_model;
      send_sample(-16'sd9, 16'sd2, RATE_W'(step));
      send_sample(-16'sd9, 16'sd2, RATE_W'(-1));
   endtask

   task automatic test_config_edges();
      write_csr(CSR_BLEND_ALPHA, 17'd131071);
      write_csr(CSR_SAMPLE_RATE, 17'd0);
      send_sample(16'sd2000, -16'sd1500, RATE_W'(3 * 65536));
      send_sample(-16'sd2000, 16'sd1500, RATE_W'(-7 * 65536));
      write_csr(CSR_SPARE_A, 17'h1FFFF);
      write_csr(CSR_SPARE_B, 17'h0AAAA);
      send_sample(16'sd12000, 16'sd9000, RATE_W'(65536));
      write_csr(CSR_BLEND_ALPHA, 17'd60000);
      write_csr(CSR_SAMPLE_RATE, {4'hF, 13'd6664});
      send_sample(16'sd12000, -16'sd9000, RATE_W'(-2000 * 65536));
   endtask

   task automatic test_random_sweep();
      for (int profile = 0; profile < 3; profile++) begin
         case (profile)
            0: begin
               send_idle_pct = 36;
               recv_idle_pct = 68;
            end
            1: begin
               send_idle_pct = 68;
               recv_idle_pct = 36;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         for (int slot = 0; slot < 3; slot++) begin
            choose_random_setting();
            for (int n = 0; n < SWEEP_ITEMS; n++) send_random_sample();
         end
      end
   endtask

   task automatic test_backpressure();
      write_csr(CSR_BLEND_ALPHA, ALPHA_RESET);
      write_csr(CSR_SAMPLE_RATE, CSR_DATA_W'(SR_RESET));
      send_idle_pct = 0;
      recv_idle_pct = 20;
      stall_request = 400;
      for (int n = 0; n < 8; n++) send_random_sample();
      wait_idle();
      for (int n = 0; n < 10; n++) send_random_sample();
      wait_idle();
   endtask

   always @(negedge clock) begin
      if (stall_request > 0) begin
         stall_left = stall_request;
         stall_request = 0;
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         angles_checked++;
         if (tilt_expect_q.size() == 0) begin
            report_mismatch($sformatf("response beat %0d with no request pending, angle %0d",
                                      angles_checked, rsp_tilt_angle));
         end else begin
            want_angle = tilt_expect_q.pop_front();
            if (rsp_tilt_angle !== want_angle)
               report_mismatch($sformatf("beat %0d tilt_angle got %0d want %0d",
                                         angles_checked, rsp_tilt_angle, want_angle));
         end
      end
   end

   initial begin
      #10ms;
      $display("timeout with %0d angles outstanding", tilt_expect_q.size());
      $display("FAILURE");
      $finish;
   end

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_accel_quadrants();
      test_gyro_wrap();
      test_config_edges();
      test_random_sweep();
      test_backpressure();
      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (tilt_expect_q.size() != 0)
         report_mismatch($sformatf("%0d expected angles never arrived", tilt_expect_q.size()));
      $display("covered %0d samples and %0d register writes, %0d angles checked",
               samples_sent, csr_writes, angles_checked);
      $display("quadrant and wrap edges, alpha and rate extremes, idle mixes, long stall");
      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
